FILE: hw/rtl/md5_pkg.sv
// Package with the payload types, state codes and round tables of the MD5 core.
`timescale 1ns / 1ps

package md5_pkg;

    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned WORD_BITS   = 32;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        last_word;
    } md5_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_of_digest;
    } md5_out_t;

    typedef logic [3:0][31:0] md5_words_t;

    typedef struct packed {
        logic load;
        logic step;
    } md5_rnd_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_PRIME,
        ST_ROUND,
        ST_FINAL,
        ST_OUT
    } md5_state_t;

    localparam md5_words_t CHAIN_INIT = {
        32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
    };

    function automatic logic [3:0] md5_msg_index(input logic [5:0] rnd);
        logic [7:0] i;
        logic [7:0] g;
        i = {4'd0, rnd[3:0]};
        unique case (rnd[5:4])
            2'd0: g = i;
            2'd1: g = 8'(8'd5 * i + 8'd1);
            2'd2: g = 8'(8'd3 * i + 8'd5);
            2'd3: g = 8'(8'd7 * i);
            default: g = i;
        endcase
        return g[3:0];
    endfunction

    function automatic logic [4:0] md5_shift(input logic [5:0] rnd);
        logic [4:0] s;
        unique case ({rnd[5:4], rnd[1:0]})
            4'd0:  s = 5'd7;
            4'd1:  s = 5'd12;
            4'd2:  s = 5'd17;
            4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;
            4'd5:  s = 5'd9;
            4'd6:  s = 5'd14;
            4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;
            4'd9:  s = 5'd11;
            4'd10: s = 5'd16;
            4'd11: s = 5'd23;
            4'd12: s = 5'd6;
            4'd13: s = 5'd10;
            4'd14: s = 5'd15;
            4'd15: s = 5'd21;
            default: s = 5'd7;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] md5_sine(input logic [5:0] rnd);
        logic [31:0] k;
        unique case (rnd)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

FILE: hw/rtl/md5_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module md5_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hw/rtl/md5_round.sv
// MD5 working registers and the datapath of one compression round.
`timescale 1ns / 1ps

module md5_round (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  md5_pkg::md5_rnd_ctrl_t ctrl,
    input  logic [5:0]            rnd,
    input  md5_pkg::md5_words_t   chain_in,
    input  logic [31:0]           msg_word,
    output md5_pkg::md5_words_t   work
);

    import md5_pkg::*;

    md5_words_t  work_reg;
    md5_words_t  work_next;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] f;
    logic [31:0] sum;
    logic [63:0] rot;

    always_comb begin
        a = work_reg[0];
        b = work_reg[1];
        c = work_reg[2];
        d = work_reg[3];
        unique case (rnd[5:4])
            2'd0: f = (b & c) | (~b & d);
            2'd1: f = (d & b) | (~d & c);
            2'd2: f = b ^ c ^ d;
            2'd3: f = c ^ (b | ~d);
            default: f = b ^ c ^ d;
        endcase
        sum = a + f + md5_sine(rnd) + msg_word;
        rot = {sum, sum} << md5_shift(rnd);
        work_next = work_reg;
        if (ctrl.load) begin
            work_next = chain_in;
        end else if (ctrl.step) begin
            work_next[0] = d;
            work_next[1] = b + rot[63:32];
            work_next[2] = b;
            work_next[3] = c;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_reg <= '0;
        end else begin
            work_reg <= work_next;
        end
    end

    assign work = work_reg;

endmodule

FILE: hw/rtl/md5_message_digest_core.sv
// Top level of the MD5 core: block buffer memory, padding sequencer and digest output.
//
//   Channel   Ports                        Carries
//   input     s_valid s_ready s_data       message words with byte count and last flag
//   result    m_valid m_ready m_data       four digest words, A first
//
// A word that does not complete a block is only written into the block buffer. A word
// that completes a block also primes the block buffer read, runs 64 rounds through the
// single round unit and adds into the chaining value. A last word then writes padding
// words, compresses each block the padding closes and sends the four digest words.
// Reset loads the initial chaining value and clears the length and word position.
// Input is not taken while padding is written, a block is compressed or a digest waits to be taken.
`timescale 1ns / 1ps

module md5_message_digest_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  md5_pkg::md5_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output md5_pkg::md5_out_t m_data
);

    import md5_pkg::*;

    md5_state_t    state_reg, state_next;
    logic [3:0]    pos_reg, pos_next;
    logic [63:0]   len_reg, len_next;
    logic          need80_reg, need80_next;
    logic          pad_reg, pad_next;
    logic          lo_done_reg, lo_done_next;
    logic          done_reg, done_next;
    logic [5:0]    rnd_reg, rnd_next;
    logic [1:0]    idx_reg, idx_next;
    md5_words_t    chain_reg, chain_next;

    logic          wr_en;
    logic [31:0]   wr_data;
    logic          rd_en;
    logic [3:0]    rd_addr;
    logic [31:0]   rd_data;
    md5_rnd_ctrl_t rnd_ctrl;
    md5_words_t    work;
    logic [2:0]    cnt_sat;

    function automatic logic [31:0] tail_word(input logic [31:0] data, input logic [2:0] cnt);
        logic [31:0] w;
        unique case (cnt)
            3'd0: w = 32'h0000_0080;
            3'd1: w = {16'h0000, 8'h80, data[7:0]};
            3'd2: w = {8'h00, 8'h80, data[15:0]};
            3'd3: w = {8'h80, data[23:0]};
            default: w = data;
        endcase
        return w;
    endfunction

    md5_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(BLOCK_WORDS)
    ) u_buf (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(pos_reg),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    md5_round u_round (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (rnd_ctrl),
        .rnd     (rnd_reg),
        .chain_in(chain_reg),
        .msg_word(rd_data),
        .work    (work)
    );

    assign cnt_sat = (s_data.byte_count > 3'd4) ? 3'd4 : s_data.byte_count;

    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        len_next     = len_reg;
        need80_next  = need80_reg;
        pad_next     = pad_reg;
        lo_done_next = lo_done_reg;
        done_next    = done_reg;
        rnd_next     = rnd_reg;
        idx_next     = idx_reg;
        chain_next   = chain_reg;
        wr_en        = 1'b0;
        wr_data      = 32'h0;
        rd_en        = 1'b0;
        rd_addr      = 4'd0;
        rnd_ctrl     = '0;
        s_ready      = 1'b0;
        m_valid      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    wr_en    = 1'b1;
                    pos_next = pos_reg + 4'd1;
                    if (!s_data.last_word) begin
                        wr_data  = s_data.data_word;
                        len_next = len_reg + 64'd32;
                    end else begin
                        wr_data     = tail_word(s_data.data_word, cnt_sat);
                        len_next    = len_reg + {58'd0, cnt_sat, 3'd0};
                        pad_next    = 1'b1;
                        need80_next = (cnt_sat == 3'd4);
                    end
                    if (pos_reg == 4'd15) begin
                        state_next = ST_PRIME;
                    end else if (s_data.last_word) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                wr_en    = 1'b1;
                pos_next = pos_reg + 4'd1;
                if (need80_reg) begin
                    wr_data     = 32'h0000_0080;
                    need80_next = 1'b0;
                end else if (pos_reg == 4'd14) begin
                    wr_data      = len_reg[31:0];
                    lo_done_next = 1'b1;
                end else if (pos_reg == 4'd15 && lo_done_reg) begin
                    wr_data   = len_reg[63:32];
                    done_next = 1'b1;
                end
                if (pos_reg == 4'd15) begin
                    state_next = ST_PRIME;
                end
            end
            ST_PRIME: begin
                rd_en         = 1'b1;
                rd_addr       = md5_msg_index(6'd0);
                rnd_ctrl.load = 1'b1;
                rnd_next      = 6'd0;
                state_next    = ST_ROUND;
            end
            ST_ROUND: begin
                rd_en         = 1'b1;
                rd_addr       = md5_msg_index(rnd_reg + 6'd1);
                rnd_ctrl.step = 1'b1;
                rnd_next      = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                for (int k = 0; k < 4; k++) begin
                    chain_next[k] = chain_reg[k] + work[k];
                end
                if (!pad_reg) begin
                    state_next = ST_IDLE;
                end else if (done_reg) begin
                    idx_next   = 2'd0;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_PAD;
                end
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd3) begin
                        chain_next   = CHAIN_INIT;
                        len_next     = 64'd0;
                        pos_next     = 4'd0;
                        pad_next     = 1'b0;
                        lo_done_next = 1'b0;
                        done_next    = 1'b0;
                        need80_next  = 1'b0;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= 4'd0;
            len_reg     <= 64'd0;
            need80_reg  <= 1'b0;
            pad_reg     <= 1'b0;
            lo_done_reg <= 1'b0;
            done_reg    <= 1'b0;
            rnd_reg     <= 6'd0;
            idx_reg     <= 2'd0;
            chain_reg   <= CHAIN_INIT;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            len_reg     <= len_next;
            need80_reg  <= need80_next;
            pad_reg     <= pad_next;
            lo_done_reg <= lo_done_next;
            done_reg    <= done_next;
            rnd_reg     <= rnd_next;
            idx_reg     <= idx_next;
            chain_reg   <= chain_next;
        end
    end

    assign m_data.digest_word    = chain_reg[idx_reg];
    assign m_data.word_index     = idx_reg;
    assign m_data.last_of_digest = (idx_reg == 2'd3);

endmodule

FILE: hw/rtl/md5_checker.sv
// Port-level assertions for the MD5 core and the bind that attaches them.
`timescale 1ns / 1ps

module md5_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input md5_pkg::md5_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input md5_pkg::md5_out_t m_data
);

    import md5_pkg::*;

    a_no_input_during_digest: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready
    ) else $error("input request taken while a digest is pending");

    a_last_flag_matches_index: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last_of_digest == (m_data.word_index == 2'd3))
    ) else $error("last_of_digest does not mark word three");

    a_index_advances: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.last_of_digest) |=>
            (m_valid && m_data.word_index == 2'($past(m_data.word_index) + 2'd1))
    ) else $error("digest words not delivered in order");

    a_no_digest_after_plain_word: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_data.last_word) |=> !m_valid
    ) else $error("digest started without a last word");

    a_result_holds: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data))
    ) else $error("stalled result request changed");

endmodule

bind md5_message_digest_core md5_checker u_md5_checker (.*);
